### rtl/bnr_pkg.sv
// ----------------------------------------------------------------------------
// bnr_pkg
// shared constants, codes and types of the scrolling banner
// ----------------------------------------------------------------------------
package bnr_pkg;

  localparam int SEG_BITS       = 7;
  localparam int NUM_DIGITS_DEF = 6;
  localparam int OUT_DIGITS     = 6;
  localparam int SW_BITS        = 10;
  localparam int KEY_BITS       = 4;
  localparam int PERIOD_BITS    = 16;
  localparam int IDX_BITS       = 4;

  localparam logic [IDX_BITS-1:0] MSG_LAST = 4'd12;

  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET      = 16'd20000;
  localparam logic [PERIOD_BITS-1:0] PERIOD_SLOW_LIMIT = 16'd40000;
  localparam logic [PERIOD_BITS-1:0] PERIOD_FAST_LIMIT = 16'd4000;
  localparam logic [PERIOD_BITS-1:0] PERIOD_UP         = 16'd2000;
  localparam logic [PERIOD_BITS-1:0] PERIOD_DOWN       = 16'd5000;
  localparam logic [PERIOD_BITS-1:0] PERIOD_MAX        = 16'd42000;

  localparam logic ITEM_TICK = 1'b0;
  localparam logic ITEM_KEY  = 1'b1;

  localparam logic [KEY_BITS-1:0] KEY_MODE  = 4'b0001;
  localparam logic [KEY_BITS-1:0] KEY_PAUSE = 4'b0010;
  localparam logic [KEY_BITS-1:0] KEY_SLOW  = 4'b0100;
  localparam logic [KEY_BITS-1:0] KEY_FAST  = 4'b1000;

  localparam logic [1:0] BMODE_IDLE   = 2'd0;
  localparam logic [1:0] BMODE_HELLO  = 2'd1;
  localparam logic [1:0] BMODE_CUSTOM = 2'd2;

  typedef logic [SEG_BITS-1:0] seg_t;

  typedef struct packed {
    logic       step;
    logic       enter_hello;
    logic       enter_custom;
    logic [1:0] bmode;
  } scroll_ctl_t;

  function automatic seg_t msg_letter(input logic [IDX_BITS-1:0] idx);
    seg_t s;
    case (idx)
      4'd0:    s = 7'h76;
      4'd1:    s = 7'h79;
      4'd2:    s = 7'h38;
      4'd3:    s = 7'h38;
      4'd4:    s = 7'h3F;
      4'd6:    s = 7'h3E;
      4'd7:    s = 7'h3E;
      4'd8:    s = 7'h3F;
      4'd9:    s = 7'h50;
      4'd10:   s = 7'h38;
      4'd11:   s = 7'h5E;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

### rtl/bnr_ifs.sv
// ----------------------------------------------------------------------------
// bnr_ifs
// valid/ready channels of the scrolling banner
// ----------------------------------------------------------------------------
interface bnr_in_if
  import bnr_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                mode;
  logic [KEY_BITS-1:0] keys;
  logic [SW_BITS-1:0]  switches;

  modport source (output valid, mode, keys, switches, input ready);
  modport sink   (input valid, mode, keys, switches, output ready);
endinterface

interface bnr_out_if
  import bnr_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [SEG_BITS-1:0]    digit0;
  logic [SEG_BITS-1:0]    digit1;
  logic [SEG_BITS-1:0]    digit2;
  logic [SEG_BITS-1:0]    digit3;
  logic [SEG_BITS-1:0]    digit4;
  logic [SEG_BITS-1:0]    digit5;
  logic [1:0]             banner_state;
  logic                   is_paused;
  logic [PERIOD_BITS-1:0] scroll_period;

  modport source (output valid, digit0, digit1, digit2, digit3, digit4, digit5,
                  banner_state, is_paused, scroll_period, input ready);
  modport sink   (input valid, digit0, digit1, digit2, digit3, digit4, digit5,
                  banner_state, is_paused, scroll_period, output ready);
endinterface

### rtl/bnr_ctrl.sv
// ----------------------------------------------------------------------------
// bnr_ctrl
// banner mode, pause, scroll period and tick counter
// ----------------------------------------------------------------------------
module bnr_ctrl
  import bnr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic                   mode,
  input  logic [KEY_BITS-1:0]    keys,
  output scroll_ctl_t            ctl,
  output logic [1:0]             bmode_nxt,
  output logic                   paused_nxt,
  output logic [PERIOD_BITS-1:0] period_nxt
);

  logic [1:0]             bmode_r;
  logic                   paused_r;
  logic [PERIOD_BITS-1:0] period_r;
  logic [PERIOD_BITS-1:0] tick_r;
  logic [PERIOD_BITS-1:0] tick_nxt;
  logic                   is_key;
  logic                   is_tick;
  logic                   wrap;
  logic                   run_key;

  assign is_key  = accept && (mode == ITEM_KEY);
  assign is_tick = accept && (mode == ITEM_TICK);
  assign run_key = is_key && !paused_r;
  assign wrap    = (period_r == '0) ||
                   (({1'b0, tick_r} + 17'd1) >= {1'b0, period_r});

  always_comb begin
    paused_nxt       = paused_r ^ (is_key && (keys == KEY_PAUSE));
    bmode_nxt        = bmode_r;
    ctl.enter_hello  = 1'b0;
    ctl.enter_custom = 1'b0;
    if (run_key && (keys == KEY_MODE)) begin
      if (bmode_r != BMODE_HELLO) begin
        bmode_nxt       = BMODE_HELLO;
        ctl.enter_hello = 1'b1;
      end else begin
        bmode_nxt        = BMODE_CUSTOM;
        ctl.enter_custom = 1'b1;
      end
    end
    period_nxt = period_r;
    if (run_key && (keys == KEY_SLOW) && (period_r <= PERIOD_SLOW_LIMIT)) begin
      period_nxt = period_r + PERIOD_UP;
    end else if (run_key && (keys == KEY_FAST) && (period_r >= PERIOD_FAST_LIMIT)) begin
      period_nxt = (period_r >= PERIOD_DOWN) ? (period_r - PERIOD_DOWN) : '0;
    end
    tick_nxt = tick_r;
    if (is_key || (is_tick && wrap)) begin
      tick_nxt = '0;
    end else if (is_tick) begin
      tick_nxt = tick_r + 16'd1;
    end
    ctl.step  = !paused_nxt && (is_key || (is_tick && wrap));
    ctl.bmode = bmode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bmode_r  <= BMODE_IDLE;
      paused_r <= 1'b0;
      period_r <= PERIOD_RESET;
      tick_r   <= '0;
    end else begin
      bmode_r  <= bmode_nxt;
      paused_r <= paused_nxt;
      period_r <= period_nxt;
      tick_r   <= tick_nxt;
    end
  end

  // period stays within slow limit plus one step
  a_period_max: assert property (@(posedge clk) disable iff (!rst_n)
    period_r <= PERIOD_MAX) else $error("scroll period out of range");

  // tick counter is zero or stays below the period
  a_tick_below: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_r == '0) || (tick_r < period_r)) else $error("tick count past period");

  // a paused tick never scrolls
  a_pause_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (is_tick && paused_r) |-> !ctl.step) else $error("step while paused");

endmodule

### rtl/bnr_scroll.sv
// ----------------------------------------------------------------------------
// bnr_scroll
// hello message shifter and custom pattern rotator
// ----------------------------------------------------------------------------
module bnr_scroll
  import bnr_pkg::*;
#(
  parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  scroll_ctl_t                      ctl,
  input  logic [SW_BITS-1:0]               switches,
  output logic [SEG_BITS*NUM_DIGITS-1:0]   shown_nxt
);

  localparam int DW = SEG_BITS * NUM_DIGITS;

  logic [DW-1:0]       hello_r,  hello_nxt,  hello_base;
  logic [DW-1:0]       custom_r, custom_nxt, custom_base;
  logic [DW-1:0]       shown_r;
  logic [IDX_BITS-1:0] idx_r, idx_nxt, idx_base;

  always_comb begin
    hello_base  = ctl.enter_hello  ? '0 : hello_r;
    idx_base    = ctl.enter_hello  ? '0 : idx_r;
    custom_base = ctl.enter_custom ? {{(DW-SW_BITS){1'b0}}, switches} : custom_r;
    hello_nxt   = hello_base;
    idx_nxt     = idx_base;
    custom_nxt  = custom_base;
    shown_nxt   = shown_r;
    if (ctl.step && (ctl.bmode == BMODE_HELLO)) begin
      hello_nxt = {hello_base[DW-SEG_BITS-1:0], msg_letter(idx_base)};
      idx_nxt   = (idx_base >= MSG_LAST) ? '0 : idx_base + 4'd1;
      shown_nxt = hello_nxt;
    end else if (ctl.step && (ctl.bmode == BMODE_CUSTOM)) begin
      shown_nxt  = custom_base;
      custom_nxt = {custom_base[DW-SEG_BITS-1:0], custom_base[DW-1 -: SEG_BITS]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hello_r  <= '0;
      custom_r <= '0;
      shown_r  <= '0;
      idx_r    <= '0;
    end else begin
      hello_r  <= hello_nxt;
      custom_r <= custom_nxt;
      shown_r  <= shown_nxt;
      idx_r    <= idx_nxt;
    end
  end

  // message index wraps after the last letter
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= MSG_LAST) else $error("letter index out of range");

endmodule

### rtl/seven_segment_scrolling_banner.sv
// ----------------------------------------------------------------------------
// seven_segment_scrolling_banner
// six-digit seven-segment scrolling banner driven by ticks and key beats
//
//   channel  dir  payload                                        handshake
//   in_bus   in   mode, keys, switches                           valid/ready
//   out_bus  out  digit0..digit5, banner_state, is_paused,       valid/ready
//                 scroll_period
//
// state updates at the input accept edge, and the result is loaded into the
// output register at that same edge
// a new beat is taken every cycle unless the output register is full
// and stalled by out_bus.ready
// synchronous active-low reset clears all state but the output payload registers, no clearing pass
// ----------------------------------------------------------------------------
module seven_segment_scrolling_banner
  import bnr_pkg::*;
#(
  parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bnr_in_if.sink    in_bus,
  bnr_out_if.source out_bus
);

  localparam int DW = SEG_BITS * NUM_DIGITS;

  scroll_ctl_t            ctl;
  logic                   accept;
  logic [1:0]             bmode_nxt;
  logic                   paused_nxt;
  logic [PERIOD_BITS-1:0] period_nxt;
  logic [DW-1:0]          shown_nxt;
  seg_t                   digits_nxt [OUT_DIGITS];
  seg_t                   digits_r   [OUT_DIGITS];
  logic [1:0]             bstate_r;
  logic                   paused_r;
  logic [PERIOD_BITS-1:0] period_r;
  logic                   out_valid_r;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign accept       = in_bus.valid && in_bus.ready;

  bnr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .mode       (in_bus.mode),
    .keys       (in_bus.keys),
    .ctl        (ctl),
    .bmode_nxt  (bmode_nxt),
    .paused_nxt (paused_nxt),
    .period_nxt (period_nxt)
  );

  bnr_scroll #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_scroll (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .switches  (in_bus.switches),
    .shown_nxt (shown_nxt)
  );

  for (genvar k = 0; k < OUT_DIGITS; k++) begin : g_dig
    if (k < NUM_DIGITS) begin : g_on
      assign digits_nxt[k] = shown_nxt[SEG_BITS*k +: SEG_BITS];
    end else begin : g_off
      assign digits_nxt[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      digits_r <= digits_nxt;
      bstate_r <= bmode_nxt;
      paused_r <= paused_nxt;
      period_r <= period_nxt;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.digit0        = digits_r[0];
  assign out_bus.digit1        = digits_r[1];
  assign out_bus.digit2        = digits_r[2];
  assign out_bus.digit3        = digits_r[3];
  assign out_bus.digit4        = digits_r[4];
  assign out_bus.digit5        = digits_r[5];
  assign out_bus.banner_state  = bstate_r;
  assign out_bus.is_paused     = paused_r;
  assign out_bus.scroll_period = period_r;

  // every accepted beat leaves a result waiting
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r) else $error("accepted beat lost its result");

  // a stalled result blocks new beats
  a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus.ready) |-> !accept) else $error("beat taken over stall");

endmodule
